// ===== hdl/rsc_pkg.sv =====
`timescale 1ns / 1ps
// shared types, constants and fixed-point helpers for the rigid/soft coupling force block
// no dependencies
package rsc_pkg;

  localparam int CB        = 21;          // bits per vector component, Q8.12
  localparam int VEC_W     = 3 * CB;
  localparam int FRAC      = 12;
  localparam int GAIN_FRAC = 8;
  localparam int GAIN_W    = 24;
  localparam int INV_W     = 20;
  localparam int IDX_W     = 12;
  localparam int VCNT_W    = 13;
  localparam int OPA_W     = CB + 1;
  localparam int OPB_W     = GAIN_W + 1;
  localparam int PROD_W    = OPA_W + OPB_W;
  localparam int ACC_W     = 48;
  localparam logic [INV_W-1:0] MAX_INV = INV_W'(1000000);

  localparam logic signed [ACC_W-1:0] SAT_HI = ACC_W'((2 ** (CB - 1)) - 1);
  localparam logic signed [ACC_W-1:0] SAT_LO = -SAT_HI - ACC_W'(1);
  localparam logic signed [ACC_W-1:0] HALF_F = ACC_W'(2 ** (FRAC - 1));
  localparam logic signed [ACC_W-1:0] HALF_G = ACC_W'(2 ** (GAIN_FRAC - 1));

  typedef enum logic [1:0] {
    FN_FRAME  = 2'd0,
    FN_ATTACH = 2'd1,
    FN_CACHE  = 2'd2,
    FN_NONE   = 2'd3
  } func_t;

  typedef enum logic [1:0] {
    REG_STIFF = 2'd0,
    REG_DAMP  = 2'd1,
    REG_INV   = 2'd2,
    REG_VCNT  = 2'd3
  } reg_idx_t;

  typedef enum logic [3:0] {
    ST_IDLE, ST_M0, ST_M1, ST_M2, ST_SUM, ST_TGT, ST_SPRING,
    ST_CR0, ST_CR1, ST_CR2, ST_VEL, ST_DAMP, ST_FORCE, ST_EMIT
  } state_t;

  typedef struct packed {
    state_t step;
    logic   load_frame;
    logic   load_item;
    logic   wr_cache;
  } cmd_t;

  typedef struct packed {
    logic out_free;
  } stat_t;

  typedef logic signed [CB-1:0] comp_t;

  function automatic comp_t sat_c(input logic signed [ACC_W-1:0] v);
    comp_t r;
    if (v > SAT_HI) r = SAT_HI[CB-1:0];
    else if (v < SAT_LO) r = SAT_LO[CB-1:0];
    else r = v[CB-1:0];
    return r;
  endfunction

  // round to nearest, ties up
  function automatic logic signed [ACC_W-1:0] rnd_f(input logic signed [ACC_W-1:0] v);
    logic signed [ACC_W-1:0] t;
    t = v + HALF_F;
    return t >>> FRAC;
  endfunction

  function automatic logic signed [ACC_W-1:0] rnd_g(input logic signed [ACC_W-1:0] v);
    logic signed [ACC_W-1:0] t;
    t = v + HALF_G;
    return t >>> GAIN_FRAC;
  endfunction

  function automatic comp_t comp(input logic [VEC_W-1:0] w, input int k);
    return w[k*CB +: CB];
  endfunction

endpackage

// ===== hdl/rsc_ram.sv =====
`timescale 1ns / 1ps
// generic single write port ram with registered read
// no dependencies
module rsc_ram #(
  parameter int WIDTH = 63,
  parameter int DEPTH = 4096
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end
endmodule

// ===== hdl/rsc_ctrl.sv =====
`timescale 1ns / 1ps
// sequencer for one attachment word at a time
// depends on rsc_pkg
module rsc_ctrl (
  input  logic           clk,
  input  logic           rst,
  input  logic           s_tvalid,
  output logic           s_tready,
  input  logic [1:0]     func,
  input  logic           in_range,
  input  rsc_pkg::stat_t stat,
  output rsc_pkg::cmd_t  cmd
);
  import rsc_pkg::*;

  state_t state, state_next;
  logic   fire;

  always_ff @(posedge clk) begin
    if (rst) state <= ST_IDLE;
    else state <= state_next;
  end

  always_comb begin
    s_tready = (state == ST_IDLE);
    fire = s_tvalid && s_tready;
    cmd.step = state;
    cmd.load_frame = fire && (func == FN_FRAME);
    cmd.load_item = fire && (func == FN_ATTACH) && in_range;
    cmd.wr_cache = fire && (func == FN_CACHE) && in_range;
    state_next = state;
    unique case (state)
      ST_IDLE:   if (cmd.load_item) state_next = ST_M0;
      ST_M0:     state_next = ST_M1;
      ST_M1:     state_next = ST_M2;
      ST_M2:     state_next = ST_SUM;
      ST_SUM:    state_next = ST_TGT;
      ST_TGT:    state_next = ST_SPRING;
      ST_SPRING: state_next = ST_CR0;
      ST_CR0:    state_next = ST_CR1;
      ST_CR1:    state_next = ST_CR2;
      ST_CR2:    state_next = ST_VEL;
      ST_VEL:    state_next = ST_DAMP;
      ST_DAMP:   state_next = ST_FORCE;
      ST_FORCE:  state_next = ST_EMIT;
      ST_EMIT:   if (stat.out_free) state_next = ST_IDLE;
      default:   state_next = ST_IDLE;
    endcase
  end

  a_start: assert property (@(posedge clk) disable iff (rst)
    cmd.load_item |=> state == ST_M0) else $error("attachment did not start");
  a_emit: assert property (@(posedge clk) disable iff (rst)
    state == ST_EMIT && stat.out_free |=> state == ST_IDLE) else $error("emit stuck");
  a_busy: assert property (@(posedge clk) disable iff (rst)
    state != ST_IDLE |-> !cmd.load_frame && !cmd.wr_cache) else $error("load while busy");
endmodule

// ===== hdl/rsc_dp.sv =====
`timescale 1ns / 1ps
// three-lane datapath: shared multiplier per lane, accumulators and output register
// depends on rsc_pkg
module rsc_dp (
  input  logic                        clk,
  input  logic                        rst,
  input  rsc_pkg::cmd_t               cmd,
  output rsc_pkg::stat_t              stat,
  input  logic [rsc_pkg::IDX_W-1:0]   in_idx,
  input  logic [rsc_pkg::VEC_W-1:0]   in_row_x,
  input  logic [rsc_pkg::VEC_W-1:0]   in_row_y,
  input  logic [rsc_pkg::VEC_W-1:0]   in_row_z,
  input  logic [rsc_pkg::VEC_W-1:0]   in_org,
  input  logic [rsc_pkg::VEC_W-1:0]   in_lin,
  input  logic [rsc_pkg::VEC_W-1:0]   in_ang,
  input  logic [rsc_pkg::VEC_W-1:0]   in_lp,
  input  logic [rsc_pkg::VEC_W-1:0]   in_pos,
  input  logic [rsc_pkg::VEC_W-1:0]   prev_pos,
  input  logic [rsc_pkg::GAIN_W-1:0]  k_gain,
  input  logic [rsc_pkg::GAIN_W-1:0]  c_gain,
  input  logic [rsc_pkg::INV_W-1:0]   inv_step,
  input  logic                        hist,
  output logic                        m_tvalid,
  input  logic                        m_tready,
  output logic [207:0]                m_tdata
);
  import rsc_pkg::*;

  comp_t row [3][3];
  comp_t org [3];
  comp_t lin [3];
  comp_t ang [3];
  comp_t lp  [3];
  comp_t pos [3];
  comp_t tgt [3];
  comp_t pv  [3];
  comp_t fv  [3];
  logic signed [OPA_W-1:0]  r [3];
  logic signed [OPA_W-1:0]  opa [3];
  logic signed [OPB_W-1:0]  opb [3];
  logic signed [PROD_W-1:0] prod [3];
  logic signed [ACC_W-1:0]  acc [3];
  logic signed [ACC_W-1:0]  frc [3];
  comp_t fs [3];
  comp_t ns [3];
  logic [IDX_W-1:0] idx;
  logic signed [OPB_W-1:0] k_s, c_s, inv_s;

  assign k_s = signed'({1'b0, k_gain});
  assign c_s = signed'({1'b0, c_gain});
  assign inv_s = signed'({{(OPB_W - INV_W){1'b0}}, inv_step});
  assign stat.out_free = !m_tvalid || m_tready;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      int j1, j2;
      j1 = (i == 2) ? 0 : i + 1;
      j2 = (i == 0) ? 2 : i - 1;
      r[i] = (OPA_W)'(tgt[i]) - (OPA_W)'(org[i]);
      opa[i] = '0;
      opb[i] = '0;
      unique case (cmd.step)
        ST_M0: begin
          opa[i] = (OPA_W)'(row[i][0]); opb[i] = (OPB_W)'(lp[0]);
        end
        ST_M1: begin
          opa[i] = (OPA_W)'(row[i][1]); opb[i] = (OPB_W)'(lp[1]);
        end
        ST_M2: begin
          opa[i] = (OPA_W)'(row[i][2]); opb[i] = (OPB_W)'(lp[2]);
        end
        ST_SPRING: begin
          opa[i] = (OPA_W)'(tgt[i]) - (OPA_W)'(pos[i]); opb[i] = k_s;
        end
        ST_CR0: begin
          opa[i] = (OPA_W)'(tgt[j2]) - (OPA_W)'(org[j2]); opb[i] = (OPB_W)'(ang[j1]);
        end
        ST_CR1: begin
          opa[i] = (OPA_W)'(tgt[j1]) - (OPA_W)'(org[j1]); opb[i] = (OPB_W)'(ang[j2]);
        end
        ST_CR2: begin
          opa[i] = (OPA_W)'(pos[i]) - (OPA_W)'(comp(prev_pos, i)); opb[i] = inv_s;
        end
        ST_DAMP: begin
          opa[i] = (OPA_W)'(pv[i]) - (OPA_W)'(fv[i]); opb[i] = c_s;
        end
        default: begin
          opa[i] = r[i]; opb[i] = '0;
        end
      endcase
      fs[i] = sat_c(frc[i]);
      ns[i] = sat_c(-(ACC_W)'(fs[i]));
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 0; k < 3; k++) begin
        row[0][k] <= '0;
        row[1][k] <= '0;
        row[2][k] <= '0;
        org[k] <= '0;
        lin[k] <= '0;
        ang[k] <= '0;
      end
    end else if (cmd.load_frame) begin
      for (int k = 0; k < 3; k++) begin
        row[0][k] <= comp(in_row_x, k);
        row[1][k] <= comp(in_row_y, k);
        row[2][k] <= comp(in_row_z, k);
        org[k] <= comp(in_org, k);
        lin[k] <= comp(in_lin, k);
        ang[k] <= comp(in_ang, k);
      end
    end
    if (cmd.load_item) begin
      idx <= in_idx;
      for (int k = 0; k < 3; k++) begin
        lp[k] <= comp(in_lp, k);
        pos[k] <= comp(in_pos, k);
      end
    end
    for (int i = 0; i < 3; i++) begin
      prod[i] <= opa[i] * opb[i];
      unique case (cmd.step)
        ST_M1, ST_CR1: acc[i] <= (ACC_W)'(prod[i]);
        ST_M2, ST_SUM: acc[i] <= acc[i] + (ACC_W)'(prod[i]);
        ST_CR2:        acc[i] <= acc[i] - (ACC_W)'(prod[i]);
        default:       acc[i] <= acc[i];
      endcase
      if (cmd.step == ST_TGT) tgt[i] <= sat_c(rnd_f(acc[i]) + (ACC_W)'(org[i]));
      if (cmd.step == ST_CR0) frc[i] <= rnd_g((ACC_W)'(prod[i]));
      if (cmd.step == ST_VEL) begin
        pv[i] <= sat_c((ACC_W)'(lin[i]) + rnd_f(acc[i]));
        fv[i] <= sat_c((ACC_W)'(prod[i]));
      end
      // damping only once a full cache sweep has been seen
      if (cmd.step == ST_FORCE && hist) frc[i] <= frc[i] + rnd_g((ACC_W)'(prod[i]));
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (cmd.step == ST_EMIT && stat.out_free) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.step == ST_EMIT && stat.out_free) begin
      m_tdata <= {7'b0,
                  tgt[2], tgt[1], tgt[0],
                  ns[2], ns[1], ns[0],
                  fs[2], fs[1], fs[0],
                  idx};
    end
  end

  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid) else $error("result dropped");
  a_load: assert property (@(posedge clk) disable iff (rst)
    cmd.step == ST_EMIT && stat.out_free |=> m_tvalid) else $error("result not shown");
  a_quiet: assert property (@(posedge clk) disable iff (rst)
    cmd.step != ST_EMIT && !m_tvalid |=> !m_tvalid) else $error("spurious result");
endmodule

// ===== hdl/rigid_soft_coupling_force.sv =====
`timescale 1ns / 1ps
// top level: config registers, prior position ram, controller and datapath
// depends on rsc_pkg, rsc_ram, rsc_ctrl, rsc_dp
// an attachment word passes through 12 sequencer steps on three lane multipliers, then
//   the emit step loads the output register once the output is free
// words are accepted only while the sequencer is idle, so an attachment is finished
//   before the next word is taken; frame and cache words leave the sequencer idle
// reset: synchronous rst restores register defaults, clears the frame and history flag;
//   the prior position ram is not cleared
module rigid_soft_coupling_force #(
  parameter int MAX_VERTICES = 4096
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_tvalid,
  output logic         s_tready,
  // vertex_index, basis_row_x, basis_row_y, basis_row_z, body_origin,
  // body_linear_velocity, body_angular_velocity, body_point, vertex_position
  input  logic [519:0] s_tdata,
  // func
  input  logic [1:0]   s_tuser,
  output logic         m_tvalid,
  input  logic         m_tready,
  // target_vertex, vertex_force, body_force, application_point
  output logic [207:0] m_tdata,
  input  logic         cfg_we,
  input  logic [1:0]   cfg_index,
  input  logic [23:0]  cfg_data
);
  import rsc_pkg::*;

  localparam int AW = $clog2(MAX_VERTICES);

  logic [GAIN_W-1:0] k_gain, c_gain;
  logic [INV_W-1:0]  inv_step, inv_clamped;
  logic [VCNT_W-1:0] vcount;
  logic              hist;
  logic [IDX_W-1:0]  idx;
  logic [16:0]       idx_ext;
  logic              in_range;
  logic [AW-1:0]     raddr;
  logic [VEC_W-1:0]  prev_pos;
  cmd_t              cmd;
  stat_t             stat;

  assign idx = s_tdata[11:0];
  assign idx_ext = {5'b0, idx};
  assign in_range = ({1'b0, idx} < vcount) && (idx_ext < 17'(MAX_VERTICES));
  assign inv_clamped = (inv_step > MAX_INV) ? MAX_INV : inv_step;

  always_ff @(posedge clk) begin
    if (rst) begin
      k_gain <= GAIN_W'(256);
      c_gain <= '0;
      inv_step <= INV_W'(60);
      vcount <= VCNT_W'(4096);
      hist <= 1'b0;
    end else begin
      if (cmd.wr_cache && ({1'b0, idx} + VCNT_W'(1) == vcount)) hist <= 1'b1;
      if (cfg_we) begin
        unique case (reg_idx_t'(cfg_index))
          REG_STIFF: k_gain <= cfg_data;
          REG_DAMP:  c_gain <= cfg_data;
          REG_INV:   inv_step <= cfg_data[INV_W-1:0];
          REG_VCNT: begin
            vcount <= cfg_data[VCNT_W-1:0];
            hist <= 1'b0;
          end
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_item) raddr <= idx_ext[AW-1:0];
  end

  rsc_ram #(.WIDTH(VEC_W), .DEPTH(MAX_VERTICES)) u_prev (
    .clk   (clk),
    .we    (cmd.wr_cache),
    .waddr (idx_ext[AW-1:0]),
    .wdata (s_tdata[515:453]),
    .raddr (raddr),
    .rdata (prev_pos)
  );

  rsc_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .func     (s_tuser),
    .in_range (in_range),
    .stat     (stat),
    .cmd      (cmd)
  );

  rsc_dp u_dp (
    .clk      (clk),
    .rst      (rst),
    .cmd      (cmd),
    .stat     (stat),
    .in_idx   (idx),
    .in_row_x (s_tdata[74:12]),
    .in_row_y (s_tdata[137:75]),
    .in_row_z (s_tdata[200:138]),
    .in_org   (s_tdata[263:201]),
    .in_lin   (s_tdata[326:264]),
    .in_ang   (s_tdata[389:327]),
    .in_lp    (s_tdata[452:390]),
    .in_pos   (s_tdata[515:453]),
    .prev_pos (prev_pos),
    .k_gain   (k_gain),
    .c_gain   (c_gain),
    .inv_step (inv_clamped),
    .hist     (hist),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

  a_vcnt_clr: assert property (@(posedge clk) disable iff (rst)
    cfg_we && cfg_index == REG_VCNT |=> !hist) else $error("history not cleared");
  a_sweep: assert property (@(posedge clk) disable iff (rst)
    cmd.wr_cache && ({1'b0, idx} + VCNT_W'(1) == vcount) &&
    !(cfg_we && cfg_index == REG_VCNT) |=> hist) else $error("history not set");
  a_rise: assert property (@(posedge clk) disable iff (rst)
    $rose(m_tvalid) |-> $past(!s_tready)) else $error("result without work");
endmodule
